[rtl/drgat_pkg.sv]
// shared constants and types of the dual rate gated animation ticker
package drgat_pkg;

   // ring counter length and the width of its phase
   localparam int RING_STEPS = 12;
   localparam int PHASE_W    = (RING_STEPS > 2) ? $clog2(RING_STEPS) : 1;

   // field widths
   localparam int TIME_W     = 32;
   localparam int IVAL_W     = 16;
   localparam int PCT_W      = 7;
   localparam int RPHASE_W   = 4;
   localparam int CSR_IDX_W  = 1;

   // fill counter end point
   localparam logic [PCT_W-1:0] FILL_MAX = PCT_W'(100);

   // register reset values
   localparam logic [IVAL_W-1:0] SPIN_RESET = IVAL_W'(80);
   localparam logic [IVAL_W-1:0] PROG_RESET = IVAL_W'(30);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SPIN = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_PROG = CSR_IDX_W'(1);

   // request codes
   localparam logic REQ_FRAME = 1'b0;
   localparam logic REQ_STOP  = 1'b1;

   // divider sequencing
   localparam int DIV_STEPS = TIME_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // what the shared divider hands back
   typedef struct packed {
      logic [IVAL_W-1:0]  rem;
      logic [PHASE_W-1:0] qmod;
      logic [PCT_W-1:0]   qsat;
      logic               qovf;
   } div_result_type;

endpackage

[rtl/drgat_if.sv]
// handshake channels of the ticker: request, response and register write

interface drgat_req_if;
   logic                             valid;
   logic                             ready;
   logic                             req_type;
   logic [drgat_pkg::TIME_W-1:0]     time_ms;

   modport source (output valid, output req_type, output time_ms, input ready);
   modport sink   (input valid, input req_type, input time_ms, output ready);
endinterface

interface drgat_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [drgat_pkg::RPHASE_W-1:0]   ring_phase;
   logic [drgat_pkg::PCT_W-1:0]      percent_done;
   logic                             ring_running;
   logic                             fill_running;
   logic                             want_next_frame;

   modport source (output valid, output ring_phase, output percent_done,
                   output ring_running, output fill_running, output want_next_frame,
                   input ready);
   modport sink   (input valid, input ring_phase, input percent_done,
                   input ring_running, input fill_running, input want_next_frame,
                   output ready);
endinterface

interface drgat_csr_if;
   logic                             valid;
   logic                             ready;
   logic [drgat_pkg::CSR_IDX_W-1:0]  index;
   logic [drgat_pkg::IVAL_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/dual_rate_gated_animation_ticker_core.sv]
// top level of the dual rate gated animation ticker: sequencer, state and channels
//
// A frame item runs through these steps from acceptance to its response: the
// elapsed time is latched at acceptance, then the accumulator adds, two passes
// of the shared 32-step restoring divider (start, 32 steps, result) and the
// publishing of the response. When the fill counter reaches 100 the interval
// multiply and subtract steps follow. A pass is skipped for a counter that is
// no longer running. A stop item is answered in the cycle after it is taken.
// A new item is taken once the previous response has been handed over.
// Register writes are always ready and must only happen while no item is in
// flight.
module dual_rate_gated_animation_ticker_core (
   input  logic              clock,
   input  logic              reset,
   drgat_req_if.sink         req_chan,
   drgat_rsp_if.source       rsp_chan,
   drgat_csr_if.sink         csr_chan
);

   // sequencer codes
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_ADD    = 4'd1;
   localparam logic [3:0] S_RSTART = 4'd2;
   localparam logic [3:0] S_RWAIT  = 4'd3;
   localparam logic [3:0] S_FSTART = 4'd4;
   localparam logic [3:0] S_FWAIT  = 4'd5;
   localparam logic [3:0] S_MUL    = 4'd6;
   localparam logic [3:0] S_FIN    = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   localparam int TW = drgat_pkg::TIME_W;
   localparam int IW = drgat_pkg::IVAL_W;
   localparam int PW = drgat_pkg::PHASE_W;
   localparam int CW = drgat_pkg::PCT_W;

   logic [3:0]    state_ff, state_in;

   // configuration
   logic [IW-1:0] spin_ff, spin_in;
   logic [IW-1:0] prog_ff, prog_in;

   // ticker state
   logic [TW-1:0] prev_ff, prev_in;
   logic          seeded_ff, seeded_in;
   logic [TW-1:0] ring_acc_ff, ring_acc_in;
   logic [TW-1:0] fill_acc_ff, fill_acc_in;
   logic [PW-1:0] phase_ff, phase_in;
   logic [CW-1:0] pct_ff, pct_in;
   logic          ring_on_ff, ring_on_in;
   logic          fill_on_ff, fill_on_in;

   // per item working registers
   logic [TW-1:0]    dt_ff, dt_in;
   logic             any_ff, any_in;
   logic [CW-1:0]    room_ff, room_in;
   logic [CW+IW-1:0] prod_ff, prod_in;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [drgat_pkg::RPHASE_W-1:0] rsp_phase_ff, rsp_phase_in;
   logic [CW-1:0]                 rsp_pct_ff, rsp_pct_in;
   logic                          rsp_ring_ff, rsp_ring_in;
   logic                          rsp_fill_ff, rsp_fill_in;
   logic                          rsp_want_ff, rsp_want_in;

   // divider hookup
   logic                        div_start;
   logic [TW-1:0]               div_dividend;
   logic [IW-1:0]               div_divisor;
   logic                        div_done;
   drgat_pkg::div_result_type   div_res;

   logic          req_fire;
   logic [IW-1:0] spin_iv;
   logic [IW-1:0] prog_iv;
   logic [TW:0]   ring_sum;
   logic [TW:0]   fill_sum;
   logic [PW:0]   phase_sum;
   logic [CW-1:0] room_now;
   logic          fill_clamp;
   logic [PW+3:0] phase_ext;
   logic          fill_on_next;
   logic          any_next;

   assign req_fire      = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr_chan.ready = 1'b1;

   // a zero interval behaves as one millisecond
   assign spin_iv = (spin_ff == '0) ? IW'(1) : spin_ff;
   assign prog_iv = (prog_ff == '0) ? IW'(1) : prog_ff;

   // divider operand selection
   always_comb begin
      div_start    = (state_ff == S_RSTART) || (state_ff == S_FSTART);
      div_dividend = (state_ff == S_FSTART) ? fill_acc_ff : ring_acc_ff;
      div_divisor  = (state_ff == S_FSTART) ? prog_iv : spin_iv;
   end

   drgat_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .result   (div_res)
   );

   // helpers for the update steps
   always_comb begin
      ring_sum   = {1'b0, ring_acc_ff} + {1'b0, dt_ff};
      fill_sum   = {1'b0, fill_acc_ff} + {1'b0, dt_ff};
      phase_sum  = {1'b0, phase_ff} + {1'b0, div_res.qmod};
      if (phase_sum >= (PW+1)'(drgat_pkg::RING_STEPS)) begin
         phase_sum = phase_sum - (PW+1)'(drgat_pkg::RING_STEPS);
      end
      room_now   = (pct_ff < drgat_pkg::FILL_MAX) ? (drgat_pkg::FILL_MAX - pct_ff) : '0;
      fill_clamp = div_res.qovf || (div_res.qsat > room_now);
      phase_ext  = {4'b0000, phase_ff};
      fill_on_next = fill_on_ff && (pct_ff < drgat_pkg::FILL_MAX);
      any_next     = any_ff || fill_on_next;
   end

   // sequencer and state updates
   always_comb begin
      state_in     = state_ff;
      spin_in      = spin_ff;
      prog_in      = prog_ff;
      prev_in      = prev_ff;
      seeded_in    = seeded_ff;
      ring_acc_in  = ring_acc_ff;
      fill_acc_in  = fill_acc_ff;
      phase_in     = phase_ff;
      pct_in       = pct_ff;
      ring_on_in   = ring_on_ff;
      fill_on_in   = fill_on_ff;
      dt_in        = dt_ff;
      any_in       = any_ff;
      room_in      = room_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_phase_in = rsp_phase_ff;
      rsp_pct_in   = rsp_pct_ff;
      rsp_ring_in  = rsp_ring_ff;
      rsp_fill_in  = rsp_fill_ff;
      rsp_want_in  = rsp_want_ff;

      // response handed over
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // register writes
      if (csr_chan.valid) begin
         case (csr_chan.index)
            drgat_pkg::REG_SPIN: spin_in = csr_chan.data;
            drgat_pkg::REG_PROG: prog_in = csr_chan.data;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_chan.req_type == drgat_pkg::REQ_STOP) begin
                  ring_on_in   = 1'b0;
                  fill_on_in   = 1'b0;
                  rsp_valid_in = 1'b1;
                  rsp_phase_in = phase_ext[3:0];
                  rsp_pct_in   = pct_ff;
                  rsp_ring_in  = 1'b0;
                  rsp_fill_in  = 1'b0;
                  rsp_want_in  = 1'b0;
               end else begin
                  dt_in     = seeded_ff ? (req_chan.time_ms - prev_ff) : '0;
                  prev_in   = req_chan.time_ms;
                  seeded_in = 1'b1;
                  any_in    = 1'b0;
                  state_in  = S_ADD;
               end
            end
         end
         S_ADD: begin
            // saturating accumulate for each running counter
            if (ring_on_ff) begin
               ring_acc_in = ring_sum[TW] ? {TW{1'b1}} : ring_sum[TW-1:0];
            end
            if (fill_on_ff) begin
               fill_acc_in = fill_sum[TW] ? {TW{1'b1}} : fill_sum[TW-1:0];
            end
            if (ring_on_ff) begin
               state_in = S_RSTART;
            end else if (fill_on_ff) begin
               state_in = S_FSTART;
            end else begin
               state_in = S_DONE;
            end
         end
         S_RSTART: begin
            state_in = S_RWAIT;
         end
         S_RWAIT: begin
            if (div_done) begin
               ring_acc_in = {{(TW-IW){1'b0}}, div_res.rem};
               phase_in    = phase_sum[PW-1:0];
               any_in      = 1'b1;
               state_in    = fill_on_ff ? S_FSTART : S_DONE;
            end
         end
         S_FSTART: begin
            state_in = S_FWAIT;
         end
         S_FWAIT: begin
            if (div_done) begin
               if (fill_clamp) begin
                  room_in  = room_now;
                  state_in = S_MUL;
               end else begin
                  fill_acc_in = {{(TW-IW){1'b0}}, div_res.rem};
                  pct_in      = pct_ff + div_res.qsat;
                  state_in    = S_DONE;
               end
            end
         end
         S_MUL: begin
            // time spent by the steps that fit before the end point
            prod_in  = room_ff * prog_iv;
            state_in = S_FIN;
         end
         S_FIN: begin
            fill_acc_in = fill_acc_ff - {{(TW-CW-IW){1'b0}}, prod_ff};
            pct_in      = pct_ff + room_ff;
            state_in    = S_DONE;
         end
         S_DONE: begin
            fill_on_in   = fill_on_next;
            any_in       = any_next;
            rsp_valid_in = 1'b1;
            rsp_phase_in = phase_ext[3:0];
            rsp_pct_in   = pct_ff;
            rsp_ring_in  = ring_on_ff;
            rsp_fill_in  = fill_on_next;
            rsp_want_in  = any_next;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         spin_ff      <= drgat_pkg::SPIN_RESET;
         prog_ff      <= drgat_pkg::PROG_RESET;
         prev_ff      <= '0;
         seeded_ff    <= 1'b0;
         ring_acc_ff  <= '0;
         fill_acc_ff  <= '0;
         phase_ff     <= '0;
         pct_ff       <= '0;
         ring_on_ff   <= 1'b1;
         fill_on_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         spin_ff      <= spin_in;
         prog_ff      <= prog_in;
         prev_ff      <= prev_in;
         seeded_ff    <= seeded_in;
         ring_acc_ff  <= ring_acc_in;
         fill_acc_ff  <= fill_acc_in;
         phase_ff     <= phase_in;
         pct_ff       <= pct_in;
         ring_on_ff   <= ring_on_in;
         fill_on_ff   <= fill_on_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dt_ff        <= dt_in;
      any_ff       <= any_in;
      room_ff      <= room_in;
      prod_ff      <= prod_in;
      rsp_phase_ff <= rsp_phase_in;
      rsp_pct_ff   <= rsp_pct_in;
      rsp_ring_ff  <= rsp_ring_in;
      rsp_fill_ff  <= rsp_fill_in;
      rsp_want_ff  <= rsp_want_in;
   end

   // response channel
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.ring_phase      = rsp_phase_ff;
   assign rsp_chan.percent_done    = rsp_pct_ff;
   assign rsp_chan.ring_running    = rsp_ring_ff;
   assign rsp_chan.fill_running    = rsp_fill_ff;
   assign rsp_chan.want_next_frame = rsp_want_ff;

   // percentage never passes the end point
   a_pct_max: assert property (@(posedge clock) disable iff (reset)
      pct_ff <= drgat_pkg::FILL_MAX)
      else $error("percentage above end point");

   // phase stays inside the ring
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, phase_ff} < (PW+1)'(drgat_pkg::RING_STEPS))
      else $error("ring phase out of range");

   // between items a running fill counter is below the end point
   a_fill_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && fill_on_ff) |-> (pct_ff < drgat_pkg::FILL_MAX))
      else $error("fill counter running at end point");

   // every accepted item is either answered or being worked on
   a_item_taken: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (rsp_valid_ff || state_ff != S_IDLE))
      else $error("accepted item dropped");

   // a response that reports the fill counter running always asks for the next frame
   a_want_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fill_ff) |-> rsp_want_ff)
      else $error("fill running without next frame request");

endmodule

[rtl/drgat_div.sv]
// shared restoring divider, one quotient bit per cycle, quotient kept modulo ring and saturated
module drgat_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [drgat_pkg::TIME_W-1:0]    dividend,
   input  logic [drgat_pkg::IVAL_W-1:0]    divisor,
   output logic                            done,
   output drgat_pkg::div_result_type       result
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [drgat_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [drgat_pkg::TIME_W-1:0]       dvd_ff, dvd_in;
   logic [drgat_pkg::IVAL_W-1:0]       div_ff, div_in;
   logic [drgat_pkg::IVAL_W-1:0]       rem_ff, rem_in;
   logic [drgat_pkg::PHASE_W-1:0]      qmod_ff, qmod_in;
   logic [drgat_pkg::PCT_W-1:0]        qs_ff, qs_in;
   logic                               ovf_ff, ovf_in;

   logic [drgat_pkg::IVAL_W:0]         partial;
   logic [drgat_pkg::IVAL_W:0]         diff;
   logic                               qbit;
   logic [drgat_pkg::PHASE_W:0]        qmod_dbl;

   // one restoring step
   always_comb begin
      partial  = {rem_ff, dvd_ff[drgat_pkg::TIME_W-1]};
      diff     = partial - {1'b0, div_ff};
      qbit     = (partial >= {1'b0, div_ff});
      qmod_dbl = {qmod_ff, qbit};
      if (qmod_dbl >= (drgat_pkg::PHASE_W+1)'(drgat_pkg::RING_STEPS)) begin
         qmod_dbl = qmod_dbl - (drgat_pkg::PHASE_W+1)'(drgat_pkg::RING_STEPS);
      end
   end

   // sequencing of the step counter and working registers
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      qmod_in = qmod_ff;
      qs_in   = qs_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
         qmod_in = '0;
         qs_in   = '0;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[drgat_pkg::TIME_W-2:0], 1'b0};
         rem_in  = qbit ? diff[drgat_pkg::IVAL_W-1:0] : partial[drgat_pkg::IVAL_W-1:0];
         qmod_in = qmod_dbl[drgat_pkg::PHASE_W-1:0];
         qs_in   = {qs_ff[drgat_pkg::PCT_W-2:0], qbit};
         ovf_in  = ovf_ff | qs_ff[drgat_pkg::PCT_W-1];
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == drgat_pkg::DIV_CNT_W'(drgat_pkg::DIV_STEPS-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      qmod_ff <= qmod_in;
      qs_ff   <= qs_in;
      ovf_ff  <= ovf_in;
   end

   assign done        = done_ff;
   assign result.rem  = rem_ff;
   assign result.qmod = qmod_ff;
   assign result.qsat = qs_ff;
   assign result.qovf = ovf_ff;

   // remainder always below the divisor once finished
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < div_ff))
      else $error("divider remainder not below divisor");

   // quotient modulo stays inside the ring
   a_qmod_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> ({1'b0, qmod_ff} < (drgat_pkg::PHASE_W+1)'(drgat_pkg::RING_STEPS)))
      else $error("divider quotient modulo out of range");

   // busy and done never together
   a_busy_done: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff))
      else $error("divider busy while reporting done");

endmodule

[test/tb_dual_rate_gated_animation_ticker_core.sv]
// self-checking testbench of the dual rate gated animation ticker core
module tb_dual_rate_gated_animation_ticker_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int DRAIN_CYCLES = 100;

   // what one response item carries
   typedef struct packed {
      logic [drgat_pkg::RPHASE_W-1:0] ring_phase;
      logic [drgat_pkg::PCT_W-1:0]    percent_done;
      logic                           ring_running;
      logic                           fill_running;
      logic                           want_next_frame;
   } tick_view_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   drgat_req_if req_bus ();
   drgat_rsp_if rsp_bus ();
   drgat_csr_if csr_bus ();

   dual_rate_gated_animation_ticker_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // mirrored ticker state and intervals
   logic [drgat_pkg::TIME_W-1:0] last_stamp;
   logic                         stamp_seen;
   logic [drgat_pkg::TIME_W-1:0] spin_accum;
   logic [drgat_pkg::TIME_W-1:0] fill_accum;
   int unsigned                  spin_phase;
   logic [drgat_pkg::PCT_W-1:0]  fill_pct;
   logic                         spin_active;
   logic                         fill_active;
   logic [drgat_pkg::IVAL_W-1:0] spin_ival;
   logic [drgat_pkg::IVAL_W-1:0] prog_ival;

   tick_view_type                pending_ticks[$];
   logic [drgat_pkg::TIME_W-1:0] stamp_now = 32'hFFFF_FF00;
   int unsigned                  send_idle_pct = 0;
   int unsigned                  rsp_stall_pct = 0;
   int                           rsp_hold_left = 0;
   int                           errors = 0;
   int                           cycle_count = 0;

   always #2 clock = ~clock;

   // timeout
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL dual_rate_gated_animation_ticker_core");
         $finish;
      end
   end

   function automatic logic [drgat_pkg::TIME_W-1:0] add_clamped(
         logic [drgat_pkg::TIME_W-1:0] a, logic [drgat_pkg::TIME_W-1:0] b);
      logic [drgat_pkg::TIME_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[drgat_pkg::TIME_W] ? '1 : sum[drgat_pkg::TIME_W-1:0];
   endfunction

   // advance the mirrored ticker by one item and return the response it gives
   function automatic tick_view_type advance_ticker(logic kind,
                                                    logic [drgat_pkg::TIME_W-1:0] stamp);
      logic [drgat_pkg::TIME_W-1:0] delta;
      logic [drgat_pkg::TIME_W-1:0] ival;
      logic [drgat_pkg::TIME_W-1:0] steps;
      int unsigned                  room;
      logic                         busy;
      tick_view_type                view;
      busy = 1'b0;
      if (kind == drgat_pkg::REQ_STOP) begin
         spin_active = 1'b0;
         fill_active = 1'b0;
      end else begin
         delta      = stamp_seen ? stamp - last_stamp : '0;
         last_stamp = stamp;
         stamp_seen = 1'b1;
         // ring counter: wraps, runs until stopped
         if (spin_active) begin
            ival       = (spin_ival == '0) ? drgat_pkg::TIME_W'(1)
                                           : drgat_pkg::TIME_W'(spin_ival);
            spin_accum = add_clamped(spin_accum, delta);
            steps      = spin_accum / ival;
            spin_accum = spin_accum % ival;
            spin_phase = (spin_phase + steps % drgat_pkg::RING_STEPS) % drgat_pkg::RING_STEPS;
            busy       = 1'b1;
         end
         // fill counter: climbs to the end point, leftover time stays
         if (fill_active) begin
            ival       = (prog_ival == '0) ? drgat_pkg::TIME_W'(1)
                                           : drgat_pkg::TIME_W'(prog_ival);
            room       = (fill_pct < drgat_pkg::FILL_MAX) ? drgat_pkg::FILL_MAX - fill_pct : 0;
            fill_accum = add_clamped(fill_accum, delta);
            steps      = fill_accum / ival;
            if (steps > room) steps = room;
            fill_accum = fill_accum - steps * ival;
            fill_pct   = fill_pct + drgat_pkg::PCT_W'(steps);
            if (fill_pct >= drgat_pkg::FILL_MAX) fill_active = 1'b0;
            else busy = 1'b1;
         end
      end
      view.ring_phase      = drgat_pkg::RPHASE_W'(spin_phase);
      view.percent_done    = fill_pct;
      view.ring_running    = spin_active;
      view.fill_running    = fill_active;
      view.want_next_frame = busy;
      return view;
   endfunction

   task automatic note_field(string label, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         errors++;
      end
   endtask

   // response side: check each accepted item, then choose ready
   always @(posedge clock) begin : rsp_side
      tick_view_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_ticks.size() == 0) begin
            $display("%0t ns: response with nothing expected, expected none, actual %0d/%0d",
                     $time, rsp_bus.ring_phase, rsp_bus.percent_done);
            errors++;
         end else begin
            want = pending_ticks.pop_front();
            note_field("ring_phase", want.ring_phase, rsp_bus.ring_phase);
            note_field("percent_done", want.percent_done, rsp_bus.percent_done);
            note_field("ring_running", want.ring_running, rsp_bus.ring_running);
            note_field("fill_running", want.fill_running, rsp_bus.fill_running);
            note_field("want_next_frame", want.want_next_frame, rsp_bus.want_next_frame);
         end
      end
      if (rsp_hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold_left--;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // offer one item, record its expected response once accepted
   task automatic send_item(input logic kind, input logic [drgat_pkg::TIME_W-1:0] stamp);
      int unsigned gap;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 90) : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.time_ms  <= stamp;
      do @(posedge clock); while (!req_bus.ready);
      pending_ticks.push_back(advance_ticker(kind, stamp));
   endtask

   task automatic send_frame_after(input logic [drgat_pkg::TIME_W-1:0] delta);
      stamp_now = stamp_now + delta;
      send_item(drgat_pkg::REQ_FRAME, stamp_now);
   endtask

   // stop offering and wait for every outstanding response
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_ticks.size() != 0);
   endtask

   // both interval registers, written back to back while idle
   task automatic write_intervals(input logic [drgat_pkg::IVAL_W-1:0] spin,
                                  input logic [drgat_pkg::IVAL_W-1:0] prog);
      drain_results();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= drgat_pkg::REG_SPIN;
      csr_bus.data  <= spin;
      do @(posedge clock); while (!csr_bus.ready);
      spin_ival = spin;
      csr_bus.index <= drgat_pkg::REG_PROG;
      csr_bus.data  <= prog;
      do @(posedge clock); while (!csr_bus.ready);
      prog_ival = prog;
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // mostly short frame gaps, some longer, a share of arbitrary 32-bit jumps
   function automatic logic [drgat_pkg::TIME_W-1:0] pick_delta(int unsigned wide_pct);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < wide_pct) return $urandom();
      if (roll < wide_pct + 15) return $urandom_range(200, 5000);
      return $urandom_range(0, 200);
   endfunction

   task automatic run_random_ticks(input int count, input int unsigned wide_pct,
                                   input int unsigned stop_pct, input int drain_every);
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(99) < stop_pct) send_item(drgat_pkg::REQ_STOP, $urandom());
         else send_frame_after(pick_delta(wide_pct));
         if (drain_every != 0 && k % drain_every == drain_every - 1) drain_results();
      end
   endtask

   // reset intervals, first frame, repeated stamp, timestamp wrap
   task automatic test_first_frames();
      set_idling(0, 0);
      send_item(drgat_pkg::REQ_FRAME, stamp_now);
      send_frame_after(0);
      send_frame_after(80);
      send_frame_after(192);
      send_frame_after(30);
      send_frame_after(29);
   endtask

   // zero interval behaves as one, largest interval
   task automatic test_interval_extremes();
      write_intervals(16'd0, 16'hFFFF);
      send_frame_after(1);
      send_frame_after(13);
      send_frame_after(300);
      write_intervals(16'hFFFF, 16'd0);
      send_frame_after(3);
      send_frame_after(0);
      write_intervals(16'hFFFF, 16'hFFFF);
      send_frame_after(65534);
      send_frame_after(1);
      send_frame_after(131071);
   endtask

   // random frames while the fill counter is still climbing
   task automatic test_random_fill_running();
      write_intervals(16'd1, 16'hFFFF);
      set_idling(0, 0);
      rsp_hold_left = 600;
      run_random_ticks(225, 0, 0, 0);
      write_intervals(drgat_pkg::IVAL_W'($urandom_range(2, 200)),
                      drgat_pkg::IVAL_W'($urandom_range(20000, 65535)));
      set_idling(56, 0);
      run_random_ticks(225, 0, 0, 0);
      write_intervals(16'd80, 16'd40000);
      set_idling(0, 56);
      run_random_ticks(225, 0, 0, 0);
      write_intervals(16'hFFFF, drgat_pkg::IVAL_W'($urandom_range(20000, 65535)));
      set_idling(30, 30);
      run_random_ticks(225, 0, 0, 0);
   endtask

   // saturating accumulators, fill reaching its end point and then frozen
   task automatic test_fill_saturation();
      write_intervals(16'hFFFF, 16'hFFFF);
      set_idling(30, 30);
      send_frame_after(65534);
      send_frame_after(32'hFFFF_FFFF);
      send_frame_after(40);
   endtask

   // random frames with only the ring counter left running
   task automatic test_random_ring_only();
      write_intervals(16'd0, 16'd0);
      set_idling(0, 0);
      run_random_ticks(250, 20, 0, 60);
      write_intervals(drgat_pkg::IVAL_W'($urandom_range(1, 65535)),
                      drgat_pkg::IVAL_W'($urandom()));
      set_idling(56, 0);
      run_random_ticks(250, 20, 0, 0);
      write_intervals(16'd12, 16'd1);
      set_idling(30, 30);
      run_random_ticks(250, 20, 0, 0);
   endtask

   // stop freezes both counters for good, so it goes last
   task automatic test_stop();
      write_intervals(16'd80, 16'd30);
      set_idling(30, 30);
      send_item(drgat_pkg::REQ_STOP, 32'hFFFF_FFFF);
      send_frame_after(100);
      send_item(drgat_pkg::REQ_STOP, 32'h0);
      send_frame_after(5);
      set_idling(0, 56);
      run_random_ticks(120, 20, 30, 0);
   endtask

   initial begin
      spin_ival   = drgat_pkg::SPIN_RESET;
      prog_ival   = drgat_pkg::PROG_RESET;
      last_stamp  = '0;
      stamp_seen  = 1'b0;
      spin_accum  = '0;
      fill_accum  = '0;
      spin_phase  = 0;
      fill_pct    = '0;
      spin_active = 1'b1;
      fill_active = 1'b1;

      req_bus.valid    <= 1'b0;
      req_bus.req_type <= drgat_pkg::REQ_FRAME;
      req_bus.time_ms  <= '0;
      csr_bus.valid    <= 1'b0;
      csr_bus.index    <= drgat_pkg::REG_SPIN;
      csr_bus.data     <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_first_frames();
      test_interval_extremes();
      test_random_fill_running();
      test_fill_saturation();
      test_random_ring_only();
      test_stop();

      // wait out the last responses and watch for stray ones
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pending_ticks.size() == 0) begin
         $display("PASS dual_rate_gated_animation_ticker_core");
      end else begin
         $display("FAIL dual_rate_gated_animation_ticker_core");
      end
      $finish;
   end

endmodule
